### src/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types and constants of the wave stencil step block.
// ----------------------------------------------------------------------------
package wss_pkg;

  // Sample format: signed Q7.16
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 16;

  // Register widths
  localparam int COLS_W    = 6;
  localparam int ROWS_W    = 12;
  localparam int RCOEF_W   = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 18;

  // Default geometry
  localparam int MAX_COLS_DEF = 32;
  localparam int MAX_ROWS_DEF = 4095;

  // Register reset values
  localparam logic [COLS_W-1:0]  NUM_COLS_RST = COLS_W'(32);
  localparam logic [ROWS_W-1:0]  NUM_ROWS_RST = ROWS_W'(32);
  localparam logic [RCOEF_W-1:0] R_COEFF_RST  = RCOEF_W'(16384);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_COLS = 2'd0,
    CFG_NUM_ROWS = 2'd1,
    CFG_R_COEFF  = 2'd2
  } cfg_idx_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t cur_x;
    sample_t cur_y;
    sample_t prev_x;
    sample_t prev_y;
    sample_t older_x;
    sample_t older_y;
  } in_item_t;

  typedef struct packed {
    sample_t next_x;
    sample_t next_y;
    logic    frame_last;
  } out_item_t;

  // current displacement of one node
  typedef struct packed {
    sample_t x;
    sample_t y;
  } pair_t;

  // operands of one node, one component
  typedef struct packed {
    sample_t up;
    sample_t dn;
    sample_t lf;
    sample_t rt;
    sample_t c0;
    sample_t u1;
    sample_t u2;
  } stencil_t;

  // load enables of the arithmetic stages
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

endpackage

### src/wave_stencil_step.sv
// ----------------------------------------------------------------------------
// wave_stencil_step
// One explicit step of the 2-D wave equation on a raster stream of nodes.
// ----------------------------------------------------------------------------
// Nodes enter in raster order, one per cycle while the output does not
// stall and no flush runs, each with current, previous and second-previous
// displacement of two components. Results follow one row behind: a node
// of row r releases the result of the node above it, so row 0 yields
// nothing. The last node of a frame starts a flush of num_cols zero nodes
// that emits the final row (frame_last set on its last node); no input
// transaction is taken during the flush. A frame of R rows and C columns
// thus gives R*C results. A result passes the registers capture,
// Laplacian, multiply by r and round/saturate (output register) in order.
// Neighbor rows live in two delay chains of cells, not in a RAM: each
// chain is MAX_COLS-1 cells long and new nodes are loaded at the cell that
// leaves exactly num_cols-1 cells to the fixed tail tap, so row length is
// set without any read mux. The first chain also carries u1/u2 of the
// node. Neighbors outside the grid read as zero. Any config register
// write restarts the frame at row 0, column 0; a write to an unused index
// is ignored. Write only when idle.
// ----------------------------------------------------------------------------
module wave_stencil_step #(
  parameter int MAX_COLS = wss_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = wss_pkg::MAX_ROWS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wss_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wss_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // node input
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  wss_pkg::in_item_t                  in_data_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output wss_pkg::out_item_t                 out_data_o
);
  import wss_pkg::*;

  localparam int ColW  = $clog2(MAX_COLS);
  localparam int RowW  = $clog2(MAX_ROWS);
  localparam int ChainN = MAX_COLS - 1;

  typedef enum logic [1:0] {
    ST_STREAM = 2'b01,
    ST_FLUSH  = 2'b10
  } state_e;

  // config registers
  logic [COLS_W-1:0]  num_cols_q;
  logic [ROWS_W-1:0]  num_rows_q;
  logic [RCOEF_W-1:0] r_coeff_q;
  logic               cfg_write;
  logic               cfg_restart;

  // raster position
  state_e          state_q, state_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  logic [COLS_W-1:0] nc_eff;
  logic [ROWS_W-1:0] nr_eff;
  logic col_end, row_end, flushing;

  // handshake and pipeline control
  logic ev_real, ev_flush, shift;
  logic emit, up_ok, lf_ok, rt_ok, last_node;
  logic adv1, adv2, adv3, adv4;
  logic v1_q, v2_q, v3_q, v4_q;
  logic last1_q, last2_q, last3_q, last4_q;
  pipe_en_t pen;

  // delay chains
  in_item_t        push;
  in_item_t        s1 [ChainN];
  pair_t           s2 [ChainN];
  logic [ChainN-1:0] head_sel;
  in_item_t        c_q;
  pair_t           l_q;
  in_item_t        rt_tap;
  pair_t           up_tap;

  // stage 1 operands
  stencil_t st_x_d, st_y_d, st_x_q, st_y_q;
  sample_t  next_x, next_y;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  // only a write that hits a real register restarts the frame
  assign cfg_restart = cfg_write && ((cfg_index_i == CFG_NUM_COLS) ||
                                     (cfg_index_i == CFG_NUM_ROWS) ||
                                     (cfg_index_i == CFG_R_COEFF));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= NUM_COLS_RST;
      num_rows_q <= NUM_ROWS_RST;
      r_coeff_q  <= R_COEFF_RST;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CFG_NUM_COLS: num_cols_q <= cfg_data_i[COLS_W-1:0];
        CFG_NUM_ROWS: num_rows_q <= cfg_data_i[ROWS_W-1:0];
        CFG_R_COEFF:  r_coeff_q  <= cfg_data_i[RCOEF_W-1:0];
        default: ;
      endcase
    end
  end

  // sizes clamped to [2, MAX]
  always_comb begin
    if (num_cols_q < COLS_W'(2)) begin
      nc_eff = COLS_W'(2);
    end else if (num_cols_q > COLS_W'(MAX_COLS)) begin
      nc_eff = COLS_W'(MAX_COLS);
    end else begin
      nc_eff = num_cols_q;
    end
    if (num_rows_q < ROWS_W'(2)) begin
      nr_eff = ROWS_W'(2);
    end else if (num_rows_q > ROWS_W'(MAX_ROWS)) begin
      nr_eff = ROWS_W'(MAX_ROWS);
    end else begin
      nr_eff = num_rows_q;
    end
  end

  // ---------------------------------------------------------------- control
  // Pipeline stages advance when empty or when the next one advances.
  assign adv4 = !v4_q || out_ready_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign flushing   = (state_q == ST_FLUSH);
  assign in_ready_o = adv1 && !flushing;
  assign ev_real    = in_valid_i && in_ready_o;
  assign ev_flush   = flushing && adv1;
  assign shift      = ev_real || ev_flush;

  assign col_end = (COLS_W'(col_q) == nc_eff - COLS_W'(1));
  assign row_end = (ROWS_W'(row_q) == nr_eff - ROWS_W'(1));

  // Flush steps act as zero nodes of a row below the frame.
  assign emit      = flushing || (row_q != '0);
  assign up_ok     = flushing || (row_q > RowW'(1));
  assign lf_ok     = (col_q != '0);
  assign rt_ok     = !col_end;
  assign last_node = flushing && col_end;

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    if (cfg_restart) begin
      state_d = ST_STREAM;
      col_d   = '0;
      row_d   = '0;
    end else if (ev_real) begin
      if (col_end && row_end) begin
        state_d = ST_FLUSH;
        col_d   = '0;
        row_d   = '0;
      end else if (col_end) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end else if (ev_flush) begin
      if (col_end) begin
        state_d = ST_STREAM;
        col_d   = '0;
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_STREAM;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  // ---------------------------------------------------------------- chains
  assign push = flushing ? '0 : in_data_i;

  // The head cell leaves num_cols-1 cells up to the tail.
  for (genvar i = 0; i < ChainN; i++) begin : g_chain
    assign head_sel[i] = (nc_eff == COLS_W'(MAX_COLS - i));

    if (i == 0) begin : g_first
      wss_cell #(.W($bits(in_item_t))) u_s1 (
        .clk_i   (clk_i),
        .shift_i (shift),
        .head_i  (head_sel[i]),
        .ext_i   (push),
        .prev_i  (push),
        .data_o  (s1[i])
      );
      wss_cell #(.W($bits(pair_t))) u_s2 (
        .clk_i   (clk_i),
        .shift_i (shift),
        .head_i  (head_sel[i]),
        .ext_i   (l_q),
        .prev_i  (l_q),
        .data_o  (s2[i])
      );
    end else begin : g_rest
      wss_cell #(.W($bits(in_item_t))) u_s1 (
        .clk_i   (clk_i),
        .shift_i (shift),
        .head_i  (head_sel[i]),
        .ext_i   (push),
        .prev_i  (s1[i-1]),
        .data_o  (s1[i])
      );
      wss_cell #(.W($bits(pair_t))) u_s2 (
        .clk_i   (clk_i),
        .shift_i (shift),
        .head_i  (head_sel[i]),
        .ext_i   (l_q),
        .prev_i  (s2[i-1]),
        .data_o  (s2[i])
      );
    end
  end

  assign rt_tap = s1[ChainN-1];
  assign up_tap = s2[ChainN-1];

  // center (with history) and left neighbor sit between the two chains
  always_ff @(posedge clk_i) begin
    if (shift) begin
      c_q   <= rt_tap;
      l_q.x <= c_q.cur_x;
      l_q.y <= c_q.cur_y;
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_comb begin
    st_x_d.up = up_ok ? up_tap.x : '0;
    st_x_d.dn = push.cur_x;
    st_x_d.lf = lf_ok ? l_q.x : '0;
    st_x_d.rt = rt_ok ? rt_tap.cur_x : '0;
    st_x_d.c0 = c_q.cur_x;
    st_x_d.u1 = c_q.prev_x;
    st_x_d.u2 = c_q.older_x;

    st_y_d.up = up_ok ? up_tap.y : '0;
    st_y_d.dn = push.cur_y;
    st_y_d.lf = lf_ok ? l_q.y : '0;
    st_y_d.rt = rt_ok ? rt_tap.cur_y : '0;
    st_y_d.c0 = c_q.cur_y;
    st_y_d.u1 = c_q.prev_y;
    st_y_d.u2 = c_q.older_y;
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      st_x_q  <= st_x_d;
      st_y_q  <= st_y_d;
      last1_q <= last_node;
    end
    if (adv2) begin
      last2_q <= last1_q;
    end
    if (adv3) begin
      last3_q <= last2_q;
    end
    if (adv4) begin
      last4_q <= last3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= shift && emit;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
      if (adv4) begin
        v4_q <= v3_q;
      end
    end
  end

  // ---------------------------------------------------------------- math
  assign pen.s2 = adv2;
  assign pen.s3 = adv3;
  assign pen.s4 = adv4;

  wss_calc u_calc_x (
    .clk_i     (clk_i),
    .en_i      (pen),
    .r_coeff_i (r_coeff_q),
    .stencil_i (st_x_q),
    .next_o    (next_x)
  );

  wss_calc u_calc_y (
    .clk_i     (clk_i),
    .en_i      (pen),
    .r_coeff_i (r_coeff_q),
    .stencil_i (st_y_q),
    .next_o    (next_y)
  );

  // ---------------------------------------------------------------- output
  assign out_valid_o           = v4_q;
  assign out_data_o.next_x     = next_x;
  assign out_data_o.next_y     = next_y;
  assign out_data_o.frame_last = last4_q;

endmodule

### src/wss_cell.sv
// ----------------------------------------------------------------------------
// wss_cell
// One cell of a delay chain: loads the chain input when it is the head,
// otherwise the content of its upstream neighbor.
// ----------------------------------------------------------------------------
module wss_cell #(
  parameter int W = 48
) (
  input  logic         clk_i,
  input  logic         shift_i,
  input  logic         head_i,
  input  logic [W-1:0] ext_i,
  input  logic [W-1:0] prev_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] data_q;
  logic [W-1:0] data_d;

  assign data_d = head_i ? ext_i : prev_i;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

### src/wss_calc.sv
// ----------------------------------------------------------------------------
// wss_calc
// Arithmetic of one component: Laplacian and history term, scaling by r,
// rounding to Q.16 and saturation. Three register stages.
// ----------------------------------------------------------------------------
module wss_calc (
  input  logic                            clk_i,
  input  wss_pkg::pipe_en_t               en_i,
  input  logic [wss_pkg::RCOEF_W-1:0]     r_coeff_i,
  input  wss_pkg::stencil_t               stencil_i,
  output wss_pkg::sample_t                next_o
);
  import wss_pkg::*;

  localparam int S     = SAMPLE_BITS;
  localparam int LapW  = S + 3;
  localparam int BaseW = S + 4;
  localparam int ProdW = RCOEF_W + 1 + LapW;
  localparam int SumW  = ProdW + 1;
  localparam int QW    = SumW - FRAC_BITS - 1;

  localparam logic signed [QW-1:0] QMax = QW'({1'b0, {(S-1){1'b1}}});
  localparam logic signed [QW-1:0] QMin = -QMax - QW'(1);
  localparam logic signed [SumW-1:0] Round = SumW'(1) <<< FRAC_BITS;

  logic signed [LapW-1:0]  lap_d, lap_q;
  logic signed [BaseW-1:0] base_d, base_q, base3_q;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [SumW-1:0]  sum;
  logic signed [QW-1:0]    q_full;
  sample_t                 next_d, next_q;

  // stage 2: lap = up + dn + lf + rt - 4*u0, base = 5*u0 - 4*u1 + u2
  always_comb begin
    lap_d = LapW'(stencil_i.up) + LapW'(stencil_i.dn) + LapW'(stencil_i.lf)
          + LapW'(stencil_i.rt) - (LapW'(stencil_i.c0) <<< 2);
    base_d = (BaseW'(stencil_i.c0) <<< 2) + BaseW'(stencil_i.c0)
           - (BaseW'(stencil_i.u1) <<< 2) + BaseW'(stencil_i.u2);
  end

  // stage 3: r * lap, r is unsigned
  assign prod_d = ProdW'($signed({1'b0, r_coeff_i})) * ProdW'(lap_q);

  // stage 4: half of the sum, ties rounded up, then clipped
  always_comb begin
    sum    = SumW'(prod_q) + (SumW'(base3_q) <<< FRAC_BITS) + Round;
    q_full = $signed(sum[SumW-1:FRAC_BITS+1]);
    if (q_full > QMax) begin
      next_d = QMax[S-1:0];
    end else if (q_full < QMin) begin
      next_d = QMin[S-1:0];
    end else begin
      next_d = q_full[S-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      lap_q  <= lap_d;
      base_q <= base_d;
    end
    if (en_i.s3) begin
      prod_q  <= prod_d;
      base3_q <= base_q;
    end
    if (en_i.s4) begin
      next_q <= next_d;
    end
  end

  assign next_o = next_q;

endmodule
